@@ rtl/spt_pkg.sv @@
package spt_pkg;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2,
        PH_IGNORE = 2'd3
    } phase_t;

    // byte class codes
    localparam logic [1:0] CLS_OPCODE = 2'd0;
    localparam logic [1:0] CLS_LENGTH = 2'd1;
    localparam logic [1:0] CLS_DATA   = 2'd2;
    localparam logic [1:0] CLS_IGNORE = 2'd3;

    // script status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNKNOWN     = 3'd1;
    localparam logic [2:0] ST_SHORT_PUSH  = 3'd2;
    localparam logic [2:0] ST_SHORT_LEN   = 3'd3;
    localparam logic [2:0] ST_DATA_MISS   = 3'd4;
    localparam logic [2:0] ST_COINBASE    = 3'd5;

    // opcode values
    localparam logic [7:0] OP_PUSH_MIN    = 8'h01;
    localparam logic [7:0] OP_PUSH_MAX    = 8'h4B;
    localparam logic [7:0] OP_PUSHDATA1   = 8'h4C;
    localparam logic [7:0] OP_PUSHDATA2   = 8'h4D;
    localparam logic [7:0] OP_PUSHDATA4   = 8'h4E;
    localparam logic [7:0] OP_ALWAYS_KNOWN = 8'hFF;

    // configuration register indexes
    localparam logic CFG_ALLOW_INVALID = 1'b0;
    localparam logic CFG_LOWEST_UNKNOWN = 1'b1;

    localparam int unsigned COUNT_FIELD_MAX = 131071;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       last_byte;
        logic       coinbase;
    } in_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  len_left;
        logic [1:0]  len_idx;
        logic [31:0] len_acc;
        logic [31:0] data_left;
        logic [2:0]  err;
        logic [16:0] elems;
        logic        direct;
    } scan_state_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [1:0]  byte_class;
        logic        opcode_invalid;
        logic        element_done;
        logic [31:0] push_length;
        logic        script_done;
        logic [2:0]  status;
        logic [16:0] element_count;
    } result_t;

    typedef struct packed {
        logic       allow_invalid;
        logic [7:0] lowest_unknown;
    } cfg_t;

endpackage

@@ rtl/spt_in_reg.sv @@
module spt_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  spt_pkg::in_item_t in_item,
    input  logic              take,
    output logic              held_valid,
    output spt_pkg::in_item_t held_item
);

    logic              valid_reg;
    logic              valid_next;
    spt_pkg::in_item_t item_reg;

    // refill whenever empty or emptied this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

@@ rtl/spt_step.sv @@
module spt_step #(
    parameter int unsigned MAX_SCRIPT_BYTES = 65536
) (
    input  spt_pkg::cfg_t        cfg,
    input  spt_pkg::scan_state_t st,
    input  spt_pkg::in_item_t    item,
    output spt_pkg::scan_state_t st_next,
    output spt_pkg::result_t     res
);

    localparam int unsigned COUNT_LIMIT =
        (MAX_SCRIPT_BYTES < spt_pkg::COUNT_FIELD_MAX) ? MAX_SCRIPT_BYTES
                                                      : spt_pkg::COUNT_FIELD_MAX;

    logic [7:0]  b;
    logic        skip;
    logic        is_unknown;
    logic        is_direct;
    logic        is_extended;
    logic [31:0] acc_or;
    logic [2:0]  len_left_dec;
    logic [31:0] data_left_dec;
    logic        at_end_open;
    spt_pkg::scan_state_t st_mid;

    assign b           = item.script_byte;
    assign skip        = item.coinbase || (st.phase == spt_pkg::PH_IGNORE);
    assign is_unknown  = (b >= cfg.lowest_unknown) && (b != spt_pkg::OP_ALWAYS_KNOWN);
    assign is_direct   = (b >= spt_pkg::OP_PUSH_MIN) && (b <= spt_pkg::OP_PUSH_MAX);
    assign is_extended = (b >= spt_pkg::OP_PUSHDATA1) && (b <= spt_pkg::OP_PUSHDATA4);
    assign len_left_dec  = st.len_left - 3'd1;
    assign data_left_dec = st.data_left - 32'd1;

    // little-endian length gather
    always_comb begin
        acc_or = st.len_acc;
        unique case (st.len_idx)
            2'd0: acc_or[7:0]   = st.len_acc[7:0]   | b;
            2'd1: acc_or[15:8]  = st.len_acc[15:8]  | b;
            2'd2: acc_or[23:16] = st.len_acc[23:16] | b;
            2'd3: acc_or[31:24] = st.len_acc[31:24] | b;
            default: acc_or = st.len_acc;
        endcase
    end

    // next state
    always_comb begin
        st_mid = st;
        if (skip) begin
            if (item.coinbase) begin
                if (st.err == spt_pkg::ST_OK) begin
                    st_mid.err = spt_pkg::ST_COINBASE;
                end
                st_mid.phase = spt_pkg::PH_IGNORE;
            end
        end else if (st.phase == spt_pkg::PH_OPCODE) begin
            if (st.elems < 17'(COUNT_LIMIT)) begin
                st_mid.elems = st.elems + 17'd1;
            end
            priority if (is_unknown) begin
                if (!cfg.allow_invalid) begin
                    st_mid.err   = spt_pkg::ST_UNKNOWN;
                    st_mid.phase = spt_pkg::PH_IGNORE;
                end
            end else if (is_direct) begin
                st_mid.len_acc   = {24'd0, b};
                st_mid.data_left = {24'd0, b};
                st_mid.direct    = 1'b1;
                st_mid.phase     = spt_pkg::PH_DATA;
            end else if (is_extended) begin
                priority if (b == spt_pkg::OP_PUSHDATA1) begin
                    st_mid.len_left = 3'd1;
                end else if (b == spt_pkg::OP_PUSHDATA2) begin
                    st_mid.len_left = 3'd2;
                end else begin
                    st_mid.len_left = 3'd4;
                end
                st_mid.len_idx = 2'd0;
                st_mid.len_acc = '0;
                st_mid.direct  = 1'b0;
                st_mid.phase   = spt_pkg::PH_LENGTH;
            end else begin
                st_mid.phase = spt_pkg::PH_OPCODE;
            end
        end else if (st.phase == spt_pkg::PH_LENGTH) begin
            st_mid.len_acc  = acc_or;
            st_mid.len_idx  = st.len_idx + 2'd1;
            st_mid.len_left = len_left_dec;
            if (len_left_dec == 3'd0) begin
                if (acc_or == 32'd0) begin
                    st_mid.phase = spt_pkg::PH_OPCODE;
                end else begin
                    st_mid.data_left = acc_or;
                    st_mid.phase     = spt_pkg::PH_DATA;
                end
            end
        end else begin
            st_mid.data_left = data_left_dec;
            if (data_left_dec == 32'd0) begin
                st_mid.phase = spt_pkg::PH_OPCODE;
            end
        end

        // script ends inside a push
        at_end_open = item.last_byte &&
                      ((st_mid.phase == spt_pkg::PH_LENGTH) ||
                       (st_mid.phase == spt_pkg::PH_DATA));
        if (at_end_open && !cfg.allow_invalid) begin
            if (st_mid.phase == spt_pkg::PH_LENGTH) begin
                st_mid.err = spt_pkg::ST_SHORT_LEN;
            end else begin
                st_mid.err = st_mid.direct ? spt_pkg::ST_SHORT_PUSH : spt_pkg::ST_DATA_MISS;
            end
        end

        st_next = st_mid;
        if (item.last_byte) begin
            st_next.phase     = spt_pkg::PH_OPCODE;
            st_next.len_left  = '0;
            st_next.len_idx   = '0;
            st_next.len_acc   = '0;
            st_next.data_left = '0;
            st_next.err       = spt_pkg::ST_OK;
            st_next.elems     = '0;
            st_next.direct    = 1'b0;
        end
    end

    // result fields
    always_comb begin
        res                = '0;
        res.byte_value     = b;
        res.byte_class     = spt_pkg::CLS_IGNORE;
        res.script_done    = item.last_byte;
        res.status         = st_mid.err;
        res.element_count  = st_mid.elems;
        if (!skip) begin
            unique case (st.phase)
                spt_pkg::PH_OPCODE: begin
                    res.byte_class = spt_pkg::CLS_OPCODE;
                    if (is_unknown) begin
                        res.opcode_invalid = cfg.allow_invalid;
                        res.element_done   = cfg.allow_invalid;
                    end else if (is_direct) begin
                        res.push_length = {24'd0, b};
                    end else if (!is_extended) begin
                        res.element_done = 1'b1;
                    end
                end
                spt_pkg::PH_LENGTH: begin
                    res.byte_class   = spt_pkg::CLS_LENGTH;
                    res.push_length  = acc_or;
                    res.element_done = (len_left_dec == 3'd0) && (acc_or == 32'd0);
                end
                default: begin
                    res.byte_class   = spt_pkg::CLS_DATA;
                    res.push_length  = st.len_acc;
                    res.element_done = (data_left_dec == 32'd0);
                end
            endcase
        end
        if (at_end_open && cfg.allow_invalid) begin
            res.element_done = 1'b1;
        end
    end

endmodule

@@ rtl/script_push_tokenizer.sv @@
// Script push tokenizer: one script byte in, one classified result out.
// Each accepted byte passes the input register, then the parse logic into
// the result register. Throughput: one byte per cycle while m_tready is high.
// The phase update sits in a single stage.
// Reset (aresetn low, synchronous): both stages empty, parse state back to
// opcode phase with all counters zero, allow_invalid = 0, lowest unknown = 186.
module script_push_tokenizer #(
    parameter int unsigned MAX_SCRIPT_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] script_byte
    input  logic        s_tlast,   // last_byte
    input  logic [0:0]  s_tuser,   // [0] coinbase

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] byte_value, [39:8] push_length, [42:40] status,
    // [59:43] element_count, [63:60] zero
    output logic [63:0] m_tdata,
    output logic        m_tlast,   // script_done
    // [1:0] byte_class, [2] opcode_invalid, [3] element_done
    output logic [3:0]  m_tuser
);

    spt_pkg::cfg_t        cfg_reg;
    spt_pkg::scan_state_t state_reg;
    spt_pkg::scan_state_t state_next;
    spt_pkg::result_t     res_reg;
    spt_pkg::result_t     res_next;
    logic                 out_valid_reg;

    spt_pkg::in_item_t    s_item;
    spt_pkg::in_item_t    held_item;
    logic                 held_valid;
    logic                 step_fire;

    // Configuration: user writes only while idle (not enforced); no handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.allow_invalid  <= 1'b0;
            cfg_reg.lowest_unknown <= 8'd186;
        end else if (cfg_we) begin
            unique case (cfg_index)
                spt_pkg::CFG_ALLOW_INVALID:  cfg_reg.allow_invalid  <= cfg_data[0];
                spt_pkg::CFG_LOWEST_UNKNOWN: cfg_reg.lowest_unknown <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_item.script_byte = s_tdata;
    assign s_item.last_byte   = s_tlast;
    assign s_item.coinbase    = s_tuser[0];

    // Advance the held byte into the result register when that register
    // is empty or its transaction completes this cycle.
    assign step_fire = held_valid && (!out_valid_reg || m_tready);

    spt_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .take       (step_fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    spt_step #(
        .MAX_SCRIPT_BYTES (MAX_SCRIPT_BYTES)
    ) u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .item    (held_item),
        .st_next (state_next),
        .res     (res_next)
    );

    // Parse state: commit only when a byte moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase     <= spt_pkg::PH_OPCODE;
            state_reg.len_left  <= '0;
            state_reg.len_idx   <= '0;
            state_reg.len_acc   <= '0;
            state_reg.data_left <= '0;
            state_reg.err       <= spt_pkg::ST_OK;
            state_reg.elems     <= '0;
            state_reg.direct    <= 1'b0;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register: hold while the downstream stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg.element_count, res_reg.status,
                       res_reg.push_length, res_reg.byte_value};
    assign m_tlast  = res_reg.script_done;
    assign m_tuser  = {res_reg.element_done, res_reg.opcode_invalid, res_reg.byte_class};

    // An ignored byte never completes an element.
    a_ignore_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == spt_pkg::CLS_IGNORE)) |-> !m_tuser[3])
        else $error("ignored byte flagged as element end");

    // A tolerated unknown flag only appears on an opcode byte.
    a_invalid_on_opcode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == spt_pkg::CLS_OPCODE))
        else $error("opcode_invalid on non-opcode byte");

    // The last byte of a script leaves the parse state cleared.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && held_item.last_byte) |=>
        ((state_reg.phase == spt_pkg::PH_OPCODE) && (state_reg.elems == 17'd0) &&
         (state_reg.err == spt_pkg::ST_OK)))
        else $error("parse state not cleared after script end");

    // The result register takes a new byte only when it is free or draining.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !step_fire)
        else $error("stalled result overwritten");

endmodule

@@ tb/sv/script_push_tokenizer_checker.sv @@
`timescale 1ns / 1ps

module script_push_tokenizer_checker #(
    parameter int unsigned MAX_SCRIPT_BYTES = 65536,
    parameter logic [7:0]  RESET_LOWEST_UNKNOWN = 8'd186
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] script_byte
    input  logic        s_tlast,   // last_byte
    input  logic [0:0]  s_tuser,   // [0] coinbase
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] byte_value, [39:8] push_length, [42:40] status,
    // [59:43] element_count, [63:60] zero
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,   // script_done
    // [1:0] byte_class, [2] opcode_invalid, [3] element_done
    input  logic [3:0]  m_tuser,
    output int          mismatch_count,
    output int          pending_results
);

    localparam int unsigned ELEMENT_LIMIT =
        (MAX_SCRIPT_BYTES < spt_pkg::COUNT_FIELD_MAX) ? MAX_SCRIPT_BYTES
                                                      : spt_pkg::COUNT_FIELD_MAX;

    spt_pkg::cfg_t        shadow_cfg;
    spt_pkg::scan_state_t scan;
    spt_pkg::result_t     expected_q[$];

    task automatic clear_scan();
        scan       = '0;
        scan.phase = spt_pkg::PH_OPCODE;
    endtask

    // Advance the parse state by one script byte and produce its result.
    task automatic tokenize_byte(input spt_pkg::in_item_t item,
                                 output spt_pkg::result_t res);
        logic [1:0]  cls;
        logic        inv;
        logic        done;
        logic [31:0] plen;
        logic [7:0]  b;
        b    = item.script_byte;
        cls  = spt_pkg::CLS_IGNORE;
        inv  = 1'b0;
        done = 1'b0;
        plen = '0;
        if (item.coinbase || scan.phase == spt_pkg::PH_IGNORE) begin
            if (item.coinbase) begin
                if (scan.err == spt_pkg::ST_OK) scan.err = spt_pkg::ST_COINBASE;
                scan.phase = spt_pkg::PH_IGNORE;
            end
        end else if (scan.phase == spt_pkg::PH_OPCODE) begin
            cls = spt_pkg::CLS_OPCODE;
            if (scan.elems < ELEMENT_LIMIT) scan.elems = scan.elems + 17'd1;
            if (b >= shadow_cfg.lowest_unknown && b != spt_pkg::OP_ALWAYS_KNOWN) begin
                if (shadow_cfg.allow_invalid) begin
                    inv  = 1'b1;
                    done = 1'b1;
                end else begin
                    scan.err   = spt_pkg::ST_UNKNOWN;
                    scan.phase = spt_pkg::PH_IGNORE;
                end
            end else if (b >= spt_pkg::OP_PUSH_MIN && b <= spt_pkg::OP_PUSH_MAX) begin
                plen           = {24'd0, b};
                scan.len_acc   = {24'd0, b};
                scan.data_left = {24'd0, b};
                scan.direct    = 1'b1;
                scan.phase     = spt_pkg::PH_DATA;
            end else if (b >= spt_pkg::OP_PUSHDATA1 && b <= spt_pkg::OP_PUSHDATA4) begin
                scan.len_left = (b == spt_pkg::OP_PUSHDATA1) ? 3'd1 :
                                (b == spt_pkg::OP_PUSHDATA2) ? 3'd2 : 3'd4;
                scan.len_idx  = 2'd0;
                scan.len_acc  = '0;
                scan.direct   = 1'b0;
                scan.phase    = spt_pkg::PH_LENGTH;
            end else begin
                done = 1'b1;
            end
        end else if (scan.phase == spt_pkg::PH_LENGTH) begin
            cls           = spt_pkg::CLS_LENGTH;
            scan.len_acc  = scan.len_acc | ({24'd0, b} << (8 * scan.len_idx));
            scan.len_idx  = scan.len_idx + 2'd1;
            scan.len_left = scan.len_left - 3'd1;
            plen          = scan.len_acc;
            if (scan.len_left == 3'd0) begin
                if (scan.len_acc == 32'd0) begin
                    done       = 1'b1;
                    scan.phase = spt_pkg::PH_OPCODE;
                end else begin
                    scan.data_left = scan.len_acc;
                    scan.phase     = spt_pkg::PH_DATA;
                end
            end
        end else begin
            cls            = spt_pkg::CLS_DATA;
            plen           = scan.len_acc;
            scan.data_left = scan.data_left - 32'd1;
            if (scan.data_left == 32'd0) begin
                done       = 1'b1;
                scan.phase = spt_pkg::PH_OPCODE;
            end
        end

        // script ends inside a push: clip when tolerant, else record why
        if (item.last_byte &&
            (scan.phase == spt_pkg::PH_LENGTH || scan.phase == spt_pkg::PH_DATA)) begin
            if (shadow_cfg.allow_invalid) done = 1'b1;
            else if (scan.phase == spt_pkg::PH_LENGTH) scan.err = spt_pkg::ST_SHORT_LEN;
            else scan.err = scan.direct ? spt_pkg::ST_SHORT_PUSH : spt_pkg::ST_DATA_MISS;
        end

        res.byte_value     = b;
        res.byte_class     = cls;
        res.opcode_invalid = inv;
        res.element_done   = done;
        res.push_length    = plen;
        res.script_done    = item.last_byte;
        res.status         = scan.err;
        res.element_count  = scan.elems;

        if (item.last_byte) clear_scan();
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        spt_pkg::in_item_t item;
        spt_pkg::result_t  want;
        if (!aresetn) begin
            shadow_cfg.allow_invalid  = 1'b0;
            shadow_cfg.lowest_unknown = RESET_LOWEST_UNKNOWN;
            clear_scan();
            expected_q.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == spt_pkg::CFG_ALLOW_INVALID) begin
                    shadow_cfg.allow_invalid = cfg_data[0];
                end else if (cfg_index == spt_pkg::CFG_LOWEST_UNKNOWN) begin
                    shadow_cfg.lowest_unknown = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                item.script_byte = s_tdata;
                item.last_byte   = s_tlast;
                item.coinbase    = s_tuser[0];
                tokenize_byte(item, want);
                expected_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with nothing expected: tdata %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("byte_value", 32'(want.byte_value), 32'(m_tdata[7:0]));
                    compare_field("push_length", want.push_length, m_tdata[39:8]);
                    compare_field("status", 32'(want.status), 32'(m_tdata[42:40]));
                    compare_field("element_count", 32'(want.element_count),
                                  32'(m_tdata[59:43]));
                    compare_field("tdata padding", 32'd0, 32'(m_tdata[63:60]));
                    compare_field("script_done", 32'(want.script_done), 32'(m_tlast));
                    compare_field("byte_class", 32'(want.byte_class), 32'(m_tuser[1:0]));
                    compare_field("opcode_invalid", 32'(want.opcode_invalid),
                                  32'(m_tuser[2]));
                    compare_field("element_done", 32'(want.element_done), 32'(m_tuser[3]));
                end
            end
        end
        pending_results <= expected_q.size();
    end

endmodule

@@ tb/sv/script_push_tokenizer_test.sv @@
`timescale 1ns / 1ps

module script_push_tokenizer_test;

    localparam int unsigned MAX_SCRIPT_BYTES     = 65536;
    localparam logic [7:0]  RESET_LOWEST_UNKNOWN = 8'd186;
    localparam logic [7:0]  OP_FALSE             = 8'h00;
    // result passes the input register, then the result register
    localparam int          LATENCY              = 2;
    // one long script of single opcodes
    localparam int          LONG_SCRIPT_LEN      = 40;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] script_byte
    logic        s_tlast;    // last_byte
    logic [0:0]  s_tuser;    // [0] coinbase
    logic        m_tvalid;
    logic        m_tready;
    // [7:0] byte_value, [39:8] push_length, [42:40] status,
    // [59:43] element_count, [63:60] zero
    logic [63:0] m_tdata;
    logic        m_tlast;    // script_done
    // [1:0] byte_class, [2] opcode_invalid, [3] element_done
    logic [3:0]  m_tuser;

    int          mismatch_count;
    int          pending_results;

    // stimulus shaping and bookkeeping
    bit                idle_on = 1'b1;
    spt_pkg::in_item_t stim_q[$];
    int                bytes_sent = 0;
    int                scripts_sent = 0;
    int                settings_used = 0;

    always #5 aclk = ~aclk;

    script_push_tokenizer #(
        .MAX_SCRIPT_BYTES(MAX_SCRIPT_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    script_push_tokenizer_checker #(
        .MAX_SCRIPT_BYTES    (MAX_SCRIPT_BYTES),
        .RESET_LOWEST_UNKNOWN(RESET_LOWEST_UNKNOWN)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_results(pending_results)
    );

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int gap_length();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Single-byte opcode that is known under the reset setting.
    function automatic logic [7:0] pick_single_op();
        case ($urandom_range(0, 2))
            0:       return OP_FALSE;
            1:       return spt_pkg::OP_ALWAYS_KNOWN;
            default: return 8'($urandom_range(spt_pkg::OP_PUSHDATA4 + 1,
                                              RESET_LOWEST_UNKNOWN - 1));
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic last, input logic cb);
        spt_pkg::in_item_t item;
        item.script_byte = b;
        item.last_byte   = last;
        item.coinbase    = cb;
        stim_q.push_back(item);
    endtask

    // Drive every queued byte, one transaction at a time. Valid stays high
    // across back-to-back transactions; it is only dropped for a gap.
    task automatic send_script();
        spt_pkg::in_item_t item;
        int                gap;
        while (stim_q.size() > 0) begin
            item = stim_q.pop_front();
            gap  = gap_length();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= item.script_byte;
            s_tlast  <= item.last_byte;
            s_tuser  <= item.coinbase;
            do @(posedge aclk); while (!s_tready);
            bytes_sent++;
        end
        scripts_sent++;
    endtask

    // Drop valid, hold until every expected result has come back, then let
    // the pipeline settle before anything touches the registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // Write both registers one after the other; enable stays high between.
    task automatic apply_settings(input logic allow, input logic [7:0] lowest);
        cfg_we    <= 1'b1;
        cfg_index <= spt_pkg::CFG_ALLOW_INVALID;
        cfg_data  <= {7'd0, allow};
        @(posedge aclk);
        cfg_index <= spt_pkg::CFG_LOWEST_UNKNOWN;
        cfg_data  <= lowest;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Mostly well-formed scripts with random content; some are cut short,
    // some carry a coinbase byte, and a few are plain noise.
    task automatic build_random_script();
        int                kind;
        int                len;
        int                n_len_bytes;
        int                n_data;
        int                cut;
        int                k;
        logic [7:0]        op;
        logic [31:0]       len_word;
        spt_pkg::in_item_t item;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 12))
                add_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 15) == 0);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    // direct push, mostly short, now and then up to the maximum
                    len = ($urandom_range(0, 9) == 0)
                        ? $urandom_range(spt_pkg::OP_PUSH_MIN, spt_pkg::OP_PUSH_MAX)
                        : $urandom_range(1, 6);
                    add_byte(len[7:0], 1'b0, 1'b0);
                    repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end else if (kind < 45) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            op = spt_pkg::OP_PUSHDATA1;
                            n_len_bytes = 1;
                        end
                        1: begin
                            op = spt_pkg::OP_PUSHDATA2;
                            n_len_bytes = 2;
                        end
                        default: begin
                            op = spt_pkg::OP_PUSHDATA4;
                            n_len_bytes = 4;
                        end
                    endcase
                    if ($urandom_range(0, 9) == 0) len_word = $urandom;
                    else len_word = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 8);
                    if (n_len_bytes == 1) len_word = len_word & 32'h0000_00FF;
                    else if (n_len_bytes == 2) len_word = len_word & 32'h0000_FFFF;
                    add_byte(op, 1'b0, 1'b0);
                    for (k = 0; k < n_len_bytes; k++) add_byte(len_word[8*k +: 8], 1'b0, 1'b0);
                    // huge declared lengths run into the end of the script
                    n_data = (len_word <= 80) ? int'(len_word) : $urandom_range(0, 5);
                    repeat (n_data) add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end else if (kind < 75) begin
                    add_byte(pick_single_op(), 1'b0, 1'b0);
                end else begin
                    add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, stim_q.size());
                while (stim_q.size() > cut) item = stim_q.pop_back();
            end
            if ($urandom_range(0, 24) == 0) begin
                k = $urandom_range(0, stim_q.size() - 1);
                item = stim_q[k];
                item.coinbase = 1'b1;
                stim_q[k] = item;
            end
        end
        item = stim_q[stim_q.size() - 1];
        item.last_byte = 1'b1;
        stim_q[stim_q.size() - 1] = item;
    endtask

    task automatic run_random(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            // whole scripts with no idling on either side now and then
            idle_on = ($urandom_range(0, 4) != 0);
            build_random_script();
            send_script();
        end
        idle_on = 1'b1;
    endtask

    // Result sink: random stalls on m_tready, mostly short.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = gap_length();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int k;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = spt_pkg::CFG_ALLOW_INVALID;
        cfg_data  = 8'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tlast   = 1'b0;
        s_tuser   = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Strict mode, reset opcode range.
        apply_settings(1'b0, RESET_LOWEST_UNKNOWN);

        // direct push, then each length-prefixed push; zero lengths end on
        // the last length byte; highest known opcode and 0xFF close the script
        add_byte(spt_pkg::OP_PUSH_MIN, 1'b0, 1'b0);
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(spt_pkg::OP_PUSHDATA1, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(spt_pkg::OP_PUSHDATA2, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h5A, 1'b0, 1'b0);
        add_byte(spt_pkg::OP_PUSHDATA4, 1'b0, 1'b0);
        repeat (4) add_byte(8'h00, 1'b0, 1'b0);
        add_byte(RESET_LOWEST_UNKNOWN - 8'd1, 1'b0, 1'b0);
        add_byte(spt_pkg::OP_ALWAYS_KNOWN, 1'b1, 1'b0);
        send_script();
        // unknown opcode: the rest of the script is ignored
        add_byte(RESET_LOWEST_UNKNOWN, 1'b0, 1'b0);
        add_byte(spt_pkg::OP_PUSH_MIN, 1'b1, 1'b0);
        send_script();
        // script ends on a direct push opcode
        add_byte(spt_pkg::OP_PUSH_MAX, 1'b1, 1'b0);
        send_script();
        // script ends inside the length bytes
        add_byte(spt_pkg::OP_PUSHDATA2, 1'b0, 1'b0);
        add_byte(8'h01, 1'b1, 1'b0);
        send_script();
        // script ends inside the pushed data
        add_byte(spt_pkg::OP_PUSHDATA1, 1'b0, 1'b0);
        add_byte(8'h05, 1'b0, 1'b0);
        add_byte(8'h01, 1'b1, 1'b0);
        send_script();
        // coinbase byte mid-script
        add_byte(OP_FALSE, 1'b0, 1'b0);
        add_byte(OP_FALSE, 1'b0, 1'b1);
        add_byte(OP_FALSE, 1'b1, 1'b0);
        send_script();

        run_random(280);

        // one long script of single opcodes, sent with no idling
        idle_on = 1'b0;
        for (k = 0; k < LONG_SCRIPT_LEN; k++)
            add_byte(pick_single_op(), k == LONG_SCRIPT_LEN - 1, 1'b0);
        send_script();
        idle_on = 1'b1;
        wait_idle();

        // Tolerant mode: unknown opcode accepted, truncated push clipped.
        apply_settings(1'b1, RESET_LOWEST_UNKNOWN);
        add_byte(RESET_LOWEST_UNKNOWN, 1'b0, 1'b0);
        add_byte(spt_pkg::OP_PUSHDATA4, 1'b0, 1'b0);
        add_byte(8'h01, 1'b1, 1'b0);
        send_script();
        run_random(250);
        wait_idle();

        // Everything but 0xFF unknown; a push-range opcode is its own element.
        apply_settings(1'b1, 8'h00);
        add_byte(8'h05, 1'b1, 1'b0);
        send_script();
        run_random(120);
        wait_idle();

        apply_settings(1'b0, 8'h00);
        run_random(120);
        wait_idle();

        // No opcode unknown at all.
        apply_settings(1'b0, 8'hFF);
        run_random(150);
        wait_idle();

        apply_settings(1'b1, 8'hFF);
        run_random(150);
        wait_idle();

        repeat (2) begin
            apply_settings(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            run_random(100);
            wait_idle();
        end

        $display("Sent %0d scripts, %0d byte transactions, under %0d register settings",
                 scripts_sent, bytes_sent, settings_used);
        $display("Included strict and tolerant truncation, coinbase bytes and opcode ranges");
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
